### rtl/mpp_pkg.sv
// mpp_pkg: shared types, register codes and coefficient constants of the
// mercator point projection unit. No dependencies; every rtl file imports it.

package mpp_pkg;

  // horner chain shape
  localparam int NUM_COEF    = 16;
  localparam int NUM_CELLS   = NUM_COEF - 1;
  localparam int CELL_STAGES = 3;
  localparam int HEAD_STAGES = 2;
  localparam int TAIL_STAGES = 7;
  localparam int LATENCY     = HEAD_STAGES + NUM_CELLS * CELL_STAGES + TAIL_STAGES;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 56;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_OFFSET = 3'd0,
    REG_X_SCALE  = 3'd1,
    REG_Y_OFFSET = 3'd2,
    REG_Y_SCALE  = 3'd3,
    REG_VIEW_W   = 3'd4,
    REG_VIEW_H   = 3'd5
  } mpp_reg_t;

  typedef struct packed {
    logic signed [29:0] x_offset;
    logic        [55:0] x_scale;
    logic signed [43:0] y_offset;
    logic        [55:0] y_scale;
    logic        [14:0] viewport_width;
    logic        [14:0] viewport_height;
  } mpp_cfg_t;

  // input word: degrees, 20 fraction bits
  typedef struct packed {
    logic signed [28:0] longitude;
    logic signed [27:0] latitude;
  } mpp_point_t;

  // result word: pixels, 8 fraction bits
  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
  } mpp_screen_t;

  // word handed from cell to cell along the horner chain
  typedef struct packed {
    logic               valid;
    logic signed [63:0] u;        // running polynomial value, q6.57
    logic        [59:0] s2;       // latitude squared, q.57
    logic        [27:0] alat;     // latitude magnitude, q.20
    logic               lat_neg;
    logic signed [28:0] lon;
  } mpp_hword_t;

  // coefficient k is mant * 10^-dec, sign from coef_neg
  localparam logic [63:0] COEF_MANT [NUM_COEF] = '{
    64'd17453288065056974, 64'd88621455747926686, 64'd66543759286927401,
    64'd9438525614268527,  64'd6728626361457436,  64'd97754101107915972,
    64'd87044049318367135, 64'd54743860481394333, 64'd24706635166875875,
    64'd8109756477389658,  64'd19384919158744696, 64'd33400810865720711,
    64'd40419356089559425, 64'd32614389778678079, 64'd15769148644800835,
    64'd34610923509293134
  };
  localparam int COEF_DEC [NUM_COEF] = '{
    18, 23, 27, 30, 33, 37, 40, 43, 46, 49, 53, 57, 61, 65, 69, 74
  };
  localparam logic COEF_NEG [NUM_COEF] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
    1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
  };

  // coefficient k scaled by 64^(2k+1) into q6.57, rounded half away from zero;
  // evaluated at elaboration only
  function automatic logic signed [63:0] mpp_coef(input int k);
    logic [319:0] acc;
    logic [63:0]  mag;
    int           sh;
    int           i;
    sh  = 6 * (2 * k + 1) + 57 + 1;
    acc = 320'(COEF_MANT[k]) << sh;
    for (i = 0; i < COEF_DEC[k]; i++) begin
      acc = acc / 320'd10;
    end
    mag = acc[63:0];
    mag = mag + 64'd1;
    mag = mag >> 1;
    if (COEF_NEG[k]) begin
      if (mag > 64'h8000_0000_0000_0000) begin
        mag = 64'h8000_0000_0000_0000;
      end
      return $signed(64'd0 - mag);
    end
    if (mag > 64'h7fff_ffff_ffff_ffff) begin
      mag = 64'h7fff_ffff_ffff_ffff;
    end
    return $signed(mag);
  endfunction

endpackage

### rtl/mpp_horner_cell.sv
// mpp_horner_cell: one horner step u <- sat64(round(u * s2 / 2^57) + coef),
// three pipeline stages. Depends on mpp_pkg.

module mpp_horner_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [63:0] coef,
  input  mpp_pkg::mpp_hword_t win,
  output mpp_pkg::mpp_hword_t wout
);
  import mpp_pkg::*;

  localparam logic [123:0] PROD_RND = 124'(1) << 56;
  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  mpp_hword_t a_w, b_w, c_w;
  logic [63:0]  umag;
  logic [63:0]  a_ll, a_hl;
  logic [59:0]  a_lh, a_hh;
  logic [123:0] b_prod;
  logic         ovf;
  logic [63:0]  m, lim, pm;
  logic signed [65:0] p66, s66;

  // word with its valid bit dropped while in reset
  function automatic mpp_hword_t hold_valid(input mpp_hword_t w, input logic clr);
    mpp_hword_t g;
    g       = w;
    g.valid = w.valid && !clr;
    return g;
  endfunction

  assign umag = win.u[63] ? (~win.u + 64'd1) : win.u;

  // stage c: scale down, clamp to the signed range, add coefficient, saturate
  always_comb begin
    ovf = |b_prod[123:121];
    m   = b_prod[120:57];
    lim = b_w.u[63] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    pm  = (ovf || m > lim) ? lim : m;
    p66 = b_w.u[63] ? -$signed({2'b00, pm}) : $signed({2'b00, pm});
    s66 = p66 + $signed({{2{coef[63]}}, coef});
    c_w = b_w;
    if (s66[65:63] == 3'b000 || s66[65:63] == 3'b111) begin
      c_w.u = s66[63:0];
    end else if (s66[65]) begin
      c_w.u = S64_MIN;
    end else begin
      c_w.u = S64_MAX;
    end
  end

  always_ff @(posedge clk) begin
    // stage a: partial products of |u| by s2
    a_w  <= hold_valid(win, rst);
    a_ll <= umag[31:0] * win.s2[31:0];
    a_lh <= umag[31:0] * win.s2[59:32];
    a_hl <= umag[63:32] * win.s2[31:0];
    a_hh <= umag[63:32] * win.s2[59:32];
    // stage b: full product plus rounding half
    b_w    <= hold_valid(a_w, rst);
    b_prod <= 124'(a_ll) + (124'(a_lh) << 32) + (124'(a_hl) << 32)
              + (124'(a_hh) << 64) + PROD_RND;
    wout   <= hold_valid(c_w, rst);
  end

`ifndef SYNTHESIS
  a_cell_valid_delay: assert property (@(posedge clk) disable iff (rst)
    wout.valid |-> $past(win.valid, CELL_STAGES))
    else $error("cell output word without input word three cycles earlier");

  a_cell_carry: assert property (@(posedge clk) disable iff (rst)
    wout.valid |-> (wout.s2 == $past(win.s2, CELL_STAGES)
                    && wout.lon == $past(win.lon, CELL_STAGES)
                    && wout.lat_neg == $past(win.lat_neg, CELL_STAGES)))
    else $error("cell lost alignment of carried fields");

  a_cell_valid_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(wout.valid))
    else $error("cell output valid unknown after reset");
`endif

endmodule

### rtl/mpp_tail.sv
// mpp_tail: turns the polynomial value into screen y and the longitude into
// screen x, seven stages, rounded and saturated. Depends on mpp_pkg.

module mpp_tail (
  input  logic                 clk,
  input  logic                 rst,
  input  mpp_pkg::mpp_cfg_t    cfg,
  input  mpp_pkg::mpp_hword_t  win,
  output logic                 done,
  output mpp_pkg::mpp_screen_t result
);
  import mpp_pkg::*;

  localparam logic [91:0]  L_RND = 92'(1) << 42;
  localparam logic [101:0] X_RND = 102'(1) << 51;
  localparam logic [119:0] Y_RND = 120'(1) << 71;

  function automatic logic [31:0] sat32(input logic [49:0] mag, input logic neg);
    if (neg) begin
      return (mag >= 50'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end
    return (mag > 50'h0_7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
  endfunction

  logic [TAIL_STAGES-1:0] vld;

  logic [63:0] umag;
  logic [59:0] t1_abl, t1_abh;
  logic        t1_lneg;
  logic signed [30:0] t1_xs;

  logic [91:0] lsum;
  logic [29:0] xmag;
  logic [47:0] t2_lmag;
  logic        t2_lneg, t2_xneg;
  logic [44:0] t2_xmv;

  logic signed [48:0] t3_ts;
  logic        t3_xneg;
  logic [63:0] t3_p0;
  logic [55:0] t3_p1;
  logic [44:0] t3_p2;
  logic [36:0] t3_p3;

  logic [47:0]  tmag;
  logic [101:0] xsum;
  logic         t4_yneg, t4_xneg;
  logic [62:0]  t4_tmv;
  logic [49:0]  t4_xres;

  logic        t5_yneg, t5_xneg;
  logic [63:0] t5_q0;
  logic [55:0] t5_q1;
  logic [62:0] t5_q2;
  logic [54:0] t5_q3;
  logic [49:0] t5_xres;

  logic [119:0] ysum;
  logic        t6_yneg, t6_xneg;
  logic [47:0] t6_yres;
  logic [49:0] t6_xres;

  always_comb begin
    umag = win.u[63] ? (~win.u + 64'd1) : win.u;
    lsum = 92'(t1_abl) + (92'(t1_abh) << 32) + L_RND;
    xmag = t1_xs[30] ? 30'(-t1_xs) : 30'(t1_xs);
    tmag = t3_ts[48] ? 48'(-t3_ts) : 48'(t3_ts);
    xsum = 102'(t3_p0) + (102'(t3_p1) << 32) + (102'(t3_p2) << 32)
           + (102'(t3_p3) << 64) + X_RND;
    ysum = 120'(t5_q0) + (120'(t5_q1) << 32) + (120'(t5_q2) << 32)
           + (120'(t5_q3) << 64) + Y_RND;
  end

  always_ff @(posedge clk) begin
    // t1: latitude times |u|, offset longitude
    t1_abl  <= win.alat * umag[31:0];
    t1_abh  <= win.alat * umag[63:32];
    t1_lneg <= win.lat_neg ^ win.u[63];
    t1_xs   <= 31'(win.lon) + 31'(cfg.x_offset);
    // t2: projected latitude q.40, x times width
    t2_lmag <= lsum[90:43];
    t2_lneg <= t1_lneg;
    t2_xneg <= t1_xs[30];
    t2_xmv  <= xmag * cfg.viewport_width;
    // t3: y offset, x scale partials
    t3_ts   <= t2_lneg ? (49'(cfg.y_offset) - $signed({1'b0, t2_lmag}))
                       : (49'(cfg.y_offset) + $signed({1'b0, t2_lmag}));
    t3_xneg <= t2_xneg;
    t3_p0   <= t2_xmv[31:0] * cfg.x_scale[31:0];
    t3_p1   <= t2_xmv[31:0] * cfg.x_scale[55:32];
    t3_p2   <= t2_xmv[44:32] * cfg.x_scale[31:0];
    t3_p3   <= t2_xmv[44:32] * cfg.x_scale[55:32];
    // t4: y times height, x done
    t4_yneg <= t3_ts[48];
    t4_tmv  <= tmag * cfg.viewport_height;
    t4_xneg <= t3_xneg;
    t4_xres <= xsum[101:52];
    // t5: y scale partials
    t5_yneg <= t4_yneg;
    t5_q0   <= t4_tmv[31:0] * cfg.y_scale[31:0];
    t5_q1   <= t4_tmv[31:0] * cfg.y_scale[55:32];
    t5_q2   <= t4_tmv[62:32] * cfg.y_scale[31:0];
    t5_q3   <= t4_tmv[62:32] * cfg.y_scale[55:32];
    t5_xneg <= t4_xneg;
    t5_xres <= t4_xres;
    // t6: y done
    t6_yneg <= t5_yneg;
    t6_yres <= ysum[119:72];
    t6_xneg <= t5_xneg;
    t6_xres <= t5_xres;
    // t7: saturate into the result word
    result.screen_x <= sat32(t6_xres, t6_xneg);
    result.screen_y <= sat32(50'(t6_yres), t6_yneg);
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[TAIL_STAGES-2:0], win.valid};
    end
  end

  assign done = vld[TAIL_STAGES-1];

endmodule

### rtl/mercator_point_projection_unit.sv
// mercator_point_projection_unit: top level, configuration registers, input
// stage, chain of horner cells and the output tail. Depends on mpp_pkg,
// mpp_horner_cell and mpp_tail.

// One point (longitude, latitude in degrees, q.20) enters on each clock at
// which start is high and busy is low; busy is high only while rst is held,
// so a new point can be given every cycle. Each point gives exactly one
// result word (screen_x, screen_y in q.8 pixels, saturated) on result, with
// done high for that single cycle, in order. The receiver cannot stall the
// block; it must take each word as it shows. The pipeline is made of 2 input
// stages (magnitude, squaring), 15 horner cells of 3 stages each (partial
// products, product sum, scale and coefficient add), and 7 output stages that
// form the projected latitude and apply offset, scale and viewport size.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// take effect at once; write them only while no point is in flight. Writes
// to an index past the last register are dropped.

module mercator_point_projection_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  mpp_pkg::mpp_point_t                point,
  output logic                               done,
  output mpp_pkg::mpp_screen_t               result,
  input  logic                               cfg_we,
  input  logic [mpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mpp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mpp_pkg::*;

  // reset values: no offsets, unit scales (q.40), 1024 by 1024 viewport
  localparam mpp_cfg_t CFG_RESET = '{
    x_offset:        30'sd0,
    x_scale:         56'd1099511627776,
    y_offset:        44'sd0,
    y_scale:         56'd1099511627776,
    viewport_width:  15'd1024,
    viewport_height: 15'd1024
  };

  // horner starts from the top coefficient
  localparam logic signed [63:0] COEF_TOP = mpp_coef(NUM_COEF - 1);

  mpp_cfg_t   cfg;
  logic       in_valid;
  logic [27:0] in_alat;
  logic       in_neg;
  logic signed [28:0] in_lon;
  logic [55:0] sq;
  mpp_hword_t h0;
  mpp_hword_t chain [NUM_CELLS+1];

  // points are refused only during reset
  assign busy = rst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (mpp_reg_t'(cfg_index))
        REG_X_OFFSET: cfg.x_offset        <= cfg_data[29:0];
        REG_X_SCALE:  cfg.x_scale         <= cfg_data[55:0];
        REG_Y_OFFSET: cfg.y_offset        <= cfg_data[43:0];
        REG_Y_SCALE:  cfg.y_scale         <= cfg_data[55:0];
        REG_VIEW_W:   cfg.viewport_width  <= cfg_data[14:0];
        REG_VIEW_H:   cfg.viewport_height <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  // latitude squared, exact: alat^2 * 2^5 is q.57
  assign sq = 56'(in_alat) * 56'(in_alat);

  // head: latitude magnitude, then square and seed the chain word
  // busy follows rst, so nothing is taken while in reset
  always_ff @(posedge clk) begin
    in_valid <= start && !busy;
    in_neg   <= point.latitude[27];
    in_alat  <= point.latitude[27] ? 28'(-point.latitude) : 28'(point.latitude);
    in_lon   <= point.longitude;
    h0.valid   <= in_valid && !rst;
    h0.u       <= COEF_TOP;
    h0.s2      <= {sq[54:0], 5'b0};
    h0.alat    <= in_alat;
    h0.lat_neg <= in_neg;
    h0.lon     <= in_lon;
  end

  assign chain[0] = h0;

  // one cell per remaining coefficient, highest first
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    localparam logic signed [63:0] CELL_COEF = mpp_coef(NUM_COEF - 2 - i);
    mpp_horner_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .coef (CELL_COEF),
      .win  (chain[i]),
      .wout (chain[i+1])
    );
  end

  // projected latitude, offsets, scales, viewport, saturation
  mpp_tail u_tail (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .win    (chain[NUM_CELLS]),
    .done   (done),
    .result (result)
  );

`ifndef SYNTHESIS
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result word without a point taken at the pipeline latency");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result word right after reset");

  a_done_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(done))
    else $error("done unknown after reset");
`endif

endmodule
